// File: rtl/core/ulrp_pkg.sv
// ----------------------------------------------------------------------------
// ulrp_pkg
// Shared types and constants of the location response parser.
// ----------------------------------------------------------------------------
package ulrp_pkg;

  localparam int AnchorCapacity = 10;
  localparam logic [7:0] TagReturn   = 8'h40;
  localparam logic [7:0] TagPosition = 8'h41;
  localparam logic [4:0] RecordLastByte = 5'd19;  // 20-byte anchor record
  localparam logic [4:0] WordLastByte   = 5'd3;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RET_TAG   = 4'd1,
    PH_RET_LEN   = 4'd2,
    PH_RET_ERR   = 4'd3,
    PH_POS_TAG   = 4'd4,
    PH_POS_LEN   = 4'd5,
    PH_X         = 4'd6,
    PH_Y         = 4'd7,
    PH_Z         = 4'd8,
    PH_QUAL      = 4'd9,
    PH_ANC_TAG   = 4'd10,
    PH_ANC_LEN   = 4'd11,
    PH_ANC_COUNT = 4'd12,
    PH_RECORD    = 4'd13
  } phase_e;

  typedef enum logic [1:0] {
    KIND_POS    = 2'd0,
    KIND_ANCHOR = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RET_TAG   = 3'd1,
    ERR_DEVICE    = 3'd2,
    ERR_POS_TAG   = 3'd3,
    ERR_TRUNCATED = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_first;
    logic       frame_last;
  } in_word_t;

  typedef struct packed {
    kind_e        result_kind;
    err_e         error_code;
    logic [31:0]  pos_x;
    logic [31:0]  pos_y;
    logic [31:0]  pos_z;
    logic [3:0]   anchor_slot;
    logic [15:0]  anchor_id;
    logic [31:0]  anchor_range;
    logic [4:0]   stored_anchors;
    logic         anchor_overflow;
  } result_t;

endpackage

// File: rtl/core/ulrp_in_stage.sv
// ----------------------------------------------------------------------------
// ulrp_in_stage
// Input register: captures one byte word and holds it until the parser
// takes it.
// ----------------------------------------------------------------------------
module ulrp_in_stage import ulrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_word_t in_word_i,
  input  logic     take_i,
  output logic     word_valid_o,
  output in_word_t word_o
);

  logic     v_q;
  in_word_t w_q;

  assign in_stall_o   = v_q & ~take_i;
  assign word_valid_o = v_q;
  assign word_o       = w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (!in_stall_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      w_q <= in_word_i;
    end
  end

endmodule

// File: rtl/core/ulrp_parser.sv
// ----------------------------------------------------------------------------
// ulrp_parser
// Running parse state and the per-byte decode: tag checks, little-endian
// word assembly, anchor record walk and result selection.
// ----------------------------------------------------------------------------
module ulrp_parser import ulrp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_word_t word_i,
  output logic     emit_o,
  output result_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  fbc_q, fbc_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] x_q, x_d;
  logic [31:0] y_q, y_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  ann_q, ann_d;
  logic [7:0]  rec_q, rec_d;

  phase_e      phase_c;
  logic [4:0]  fbc_c;
  logic [7:0]  ann_c;
  logic [7:0]  rec_c;
  logic [1:0]  k;
  logic [31:0] word_new;
  logic        err_hit;
  err_e        err_code;
  logic        done_hit;
  logic        pos_due;
  logic        anc_due;
  logic        active;

  // Byte lane for word assembly: position words use the count directly,
  // record distance starts two bytes into the record.
  always_comb begin
    fbc_c = word_i.frame_first ? 5'd0 : fbc_q;
    if (phase_c == PH_RECORD) begin
      k = 2'(fbc_c - 5'd2);
    end else begin
      k = fbc_c[1:0];
    end
    word_new = ((k == 2'd0) ? 32'd0 : asm_q) | (32'(word_i.rx_byte) << {k, 3'b000});
  end

  always_comb begin
    phase_c = word_i.frame_first ? PH_RET_TAG : phase_q;
    ann_c   = word_i.frame_first ? 8'd0 : ann_q;
    rec_c   = word_i.frame_first ? 8'd0 : rec_q;

    phase_d  = phase_c;
    fbc_d    = fbc_c;
    asm_d    = asm_q;
    x_d      = x_q;
    y_d      = y_q;
    id_d     = id_q;
    ann_d    = ann_c;
    rec_d    = rec_c;
    err_hit  = 1'b0;
    err_code = ERR_NONE;
    done_hit = 1'b0;
    pos_due  = 1'b0;
    anc_due  = 1'b0;
    active   = 1'b1;

    case (phase_c)
      PH_RET_TAG: begin
        phase_d = PH_RET_LEN;
        if (word_i.rx_byte != TagReturn) begin
          err_hit  = 1'b1;
          err_code = ERR_RET_TAG;
        end
      end
      PH_RET_LEN: phase_d = PH_RET_ERR;
      PH_RET_ERR: begin
        phase_d = PH_POS_TAG;
        if (word_i.rx_byte != 8'd0) begin
          err_hit  = 1'b1;
          err_code = ERR_DEVICE;
        end
      end
      PH_POS_TAG: begin
        phase_d = PH_POS_LEN;
        if (word_i.rx_byte != TagPosition) begin
          err_hit  = 1'b1;
          err_code = ERR_POS_TAG;
        end
      end
      PH_POS_LEN: begin
        fbc_d   = 5'd0;
        phase_d = PH_X;
      end
      PH_X, PH_Y, PH_Z: begin
        asm_d = word_new;
        if (fbc_c >= WordLastByte) begin
          fbc_d = 5'd0;
          case (phase_c)
            PH_X: begin
              x_d     = word_new;
              phase_d = PH_Y;
            end
            PH_Y: begin
              y_d     = word_new;
              phase_d = PH_Z;
            end
            default: begin
              phase_d = PH_QUAL;
              pos_due = 1'b1;
            end
          endcase
        end else begin
          fbc_d = fbc_c + 5'd1;
        end
      end
      PH_QUAL:    phase_d = PH_ANC_TAG;
      PH_ANC_TAG: phase_d = PH_ANC_LEN;
      PH_ANC_LEN: phase_d = PH_ANC_COUNT;
      PH_ANC_COUNT: begin
        ann_d   = word_i.rx_byte;
        rec_d   = 8'd0;
        fbc_d   = 5'd0;
        phase_d = PH_RECORD;
        if (word_i.rx_byte == 8'd0) begin
          done_hit = 1'b1;
        end
      end
      PH_RECORD: begin
        if (fbc_c == 5'd0) begin
          id_d = {8'd0, word_i.rx_byte};
        end else if (fbc_c == 5'd1) begin
          id_d = {word_i.rx_byte, id_q[7:0]};
        end else if (fbc_c <= 5'd5) begin
          asm_d = word_new;
          if (fbc_c == 5'd5 && rec_c < 8'(AnchorCapacity)) begin
            anc_due = 1'b1;
          end
        end
        if (fbc_c >= RecordLastByte) begin
          fbc_d = 5'd0;
          rec_d = rec_c + 8'd1;
          if (rec_d >= ann_c) begin
            done_hit = 1'b1;
          end
        end else begin
          fbc_d = fbc_c + 5'd1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        active  = 1'b0;
      end
    endcase

    // Build the result; unused fields stay zero.
    res_o  = '0;
    emit_o = 1'b0;
    if (active) begin
      if (err_hit) begin
        emit_o            = 1'b1;
        res_o.result_kind = KIND_ERROR;
        res_o.error_code  = err_code;
        phase_d           = PH_IDLE;
      end else if (done_hit) begin
        emit_o               = 1'b1;
        res_o.result_kind    = KIND_DONE;
        res_o.anchor_overflow = (ann_d > 8'(AnchorCapacity));
        res_o.stored_anchors = res_o.anchor_overflow ? 5'(AnchorCapacity) : ann_d[4:0];
        phase_d              = PH_IDLE;
      end else if (word_i.frame_last) begin
        emit_o            = 1'b1;
        res_o.result_kind = KIND_ERROR;
        res_o.error_code  = ERR_TRUNCATED;
        phase_d           = PH_IDLE;
      end else if (pos_due) begin
        emit_o            = 1'b1;
        res_o.result_kind = KIND_POS;
        res_o.pos_x       = x_q;
        res_o.pos_y       = y_q;
        res_o.pos_z       = word_new;
      end else if (anc_due) begin
        emit_o             = 1'b1;
        res_o.result_kind  = KIND_ANCHOR;
        res_o.anchor_slot  = rec_c[3:0];
        res_o.anchor_id    = id_q;
        res_o.anchor_range = word_new;
      end
    end
    emit_o = emit_o & fire_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      fbc_q   <= 5'd0;
      ann_q   <= 8'd0;
      rec_q   <= 8'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      ann_q   <= ann_d;
      rec_q   <= rec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      asm_q <= asm_d;
      x_q   <= x_d;
      y_q   <= y_d;
      id_q  <= id_d;
    end
  end

endmodule

// File: rtl/core/ulrp_out_stage.sv
// ----------------------------------------------------------------------------
// ulrp_out_stage
// Result register: holds a result word until the consumer takes it.
// ----------------------------------------------------------------------------
module ulrp_out_stage import ulrp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    v_q;
  result_t r_q;

  assign ready_o     = ~v_q | ~out_stall_i;
  assign out_valid_o = v_q;
  assign res_o       = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      r_q <= res_i;
    end
  end

endmodule

// File: rtl/core/uwb_location_response_parser.sv
// A byte that yields a result passes from the input register through the
// parser decode into the result register; a stalled result side delays it.
// Throughput: one byte per cycle while the result side does not stall; the
// parser's per-byte state update is the single loop.
// Reset: rst_ni clears the parse phase and both stage valids; the parser then
// ignores bytes until one marked frame_first arrives.
// ----------------------------------------------------------------------------
// uwb_location_response_parser
// Streaming parser of a UWB location response: position, anchor records,
// done and error results.
// ----------------------------------------------------------------------------
module uwb_location_response_parser import ulrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_first_i,
  input  logic        frame_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] pos_x_o,
  output logic [31:0] pos_y_o,
  output logic [31:0] pos_z_o,
  output logic [3:0]  anchor_slot_o,
  output logic [15:0] anchor_id_o,
  output logic [31:0] anchor_range_o,
  output logic [4:0]  stored_anchors_o,
  output logic        anchor_overflow_o
);

  in_word_t in_word;
  in_word_t word;
  logic     word_valid;
  logic     out_ready;
  logic     fire;
  logic     emit;
  result_t  res;
  result_t  res_q;

  assign in_word = '{rx_byte: rx_byte_i, frame_first: frame_first_i,
                     frame_last: frame_last_i};
  assign fire    = word_valid & out_ready;

  ulrp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word),
    .take_i       (out_ready),
    .word_valid_o (word_valid),
    .word_o       (word)
  );

  ulrp_parser u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (word),
    .emit_o (emit),
    .res_o  (res)
  );

  ulrp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign result_kind_o     = res_q.result_kind;
  assign error_code_o      = res_q.error_code;
  assign pos_x_o           = res_q.pos_x;
  assign pos_y_o           = res_q.pos_y;
  assign pos_z_o           = res_q.pos_z;
  assign anchor_slot_o     = res_q.anchor_slot;
  assign anchor_id_o       = res_q.anchor_id;
  assign anchor_range_o    = res_q.anchor_range;
  assign stored_anchors_o  = res_q.stored_anchors;
  assign anchor_overflow_o = res_q.anchor_overflow;

endmodule

// File: rtl/core/ulrp_checker.sv
// ----------------------------------------------------------------------------
// ulrp_checker
// Port-level checks of the location response parser, bound to the top level.
// ----------------------------------------------------------------------------
module ulrp_checker import ulrp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  result_kind_o,
  input logic [2:0]  error_code_o,
  input logic [3:0]  anchor_slot_o,
  input logic [4:0]  stored_anchors_o,
  input logic        anchor_overflow_o
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result word dropped");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match result kind");

  a_anchor_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_ANCHOR |-> anchor_slot_o < 4'(AnchorCapacity))
    else $error("anchor slot beyond capacity");

  a_done_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_DONE |->
      stored_anchors_o <= 5'(AnchorCapacity) &&
      (!anchor_overflow_o || stored_anchors_o == 5'(AnchorCapacity)))
    else $error("stored anchor count inconsistent");

endmodule

bind uwb_location_response_parser ulrp_checker u_ulrp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .result_kind_o     (result_kind_o),
  .error_code_o      (error_code_o),
  .anchor_slot_o     (anchor_slot_o),
  .stored_anchors_o  (stored_anchors_o),
  .anchor_overflow_o (anchor_overflow_o)
);
